@@ rtl/sipq_pkg.sv @@
// Shared types and constants for the sorted-insert priority queue.
// Used by the slot memory, the sequencer and the top level; no dependencies.
package sipq_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int PRI_W = 8;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Item field widths on the stream ports
  localparam int PRI_FIELD_W = 8;
  localparam int CODE_W      = 32;
  localparam int QTY_W       = 16;
  localparam int COUNT_FIELD_W = 5;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry
  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [CODE_W-1:0] code;
    logic [QTY_W-1:0]  qty;
  } entry_t;

  // One request as seen by the sequencer
  typedef struct packed {
    logic   req_type;
    entry_t item;
  } request_t;

  // One result word
  typedef struct packed {
    status_t                  status;
    logic                     out_valid;
    logic [PRI_FIELD_W-1:0]   out_priority;
    logic [CODE_W-1:0]        out_code;
    logic [QTY_W-1:0]         out_quantity;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic                     is_empty;
    logic                     is_full;
  } result_t;

endpackage

@@ rtl/sipq_slot_ram.sv @@
// Slot memory of the priority queue: one write port, one read port with
// registered read data. Depends on sipq_pkg for the entry type and depth.
module sipq_slot_ram
  import sipq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sipq_ctrl.sv @@
// Sequencer of the priority queue: circular slot buffer with a head pointer,
// backward scan that compares and shifts one entry at a time, one address unit.
// Depends on sipq_pkg and drives sipq_slot_ram.
module sipq_ctrl
  import sipq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  request_t in_req,
  output logic     res_valid,
  input  logic     res_ready,
  output result_t  res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_WRITE,
    S_POP,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] pos;
  entry_t           item;

  // Memory port signals
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  // Address unit: logical index to physical slot
  logic [IDX_W-1:0] log_idx;
  logic [IDX_W:0]   phys_sum;
  logic [IDX_W-1:0] phys_addr;

  logic             is_less;
  logic [IDX_W-1:0] head_inc;

  sipq_slot_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Build a result word from a status, an optional entry and the new count
  function automatic result_t make_res(status_t st, logic vld, entry_t e,
                                       logic [CNT_W-1:0] cnt);
    result_t r;
    r.status       = st;
    r.out_valid    = vld;
    r.out_priority = vld ? PRI_FIELD_W'(e.pri) : '0;
    r.out_code     = vld ? e.code : '0;
    r.out_quantity = vld ? e.qty : '0;
    r.entry_count  = COUNT_FIELD_W'(cnt);
    r.is_empty     = (cnt == '0);
    r.is_full      = (cnt == CNT_W'(DEPTH));
    return r;
  endfunction

  // Wrap the logical index around the head
  assign phys_sum  = {1'b0, head} + {1'b0, log_idx};
  assign phys_addr = (phys_sum >= (IDX_W+1)'(DEPTH)) ?
                     IDX_W'(phys_sum - (IDX_W+1)'(DEPTH)) : IDX_W'(phys_sum);

  // Shared compare: stored entry strictly below the new priority
  assign is_less  = (ram_rdata.pri < item.pri);
  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Memory port control per state
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = item;
    log_idx   = '0;
    unique case (state)
      S_IDLE: begin
        ram_re = in_valid && (in_req.req_type == REQ_REMOVE) && (count != '0);
      end
      S_READ: begin
        log_idx = scan;
        ram_re  = 1'b1;
      end
      S_CMP: begin
        log_idx = scan + 1'b1;
        if (is_less) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      S_WRITE: begin
        log_idx = pos;
        ram_we  = 1'b1;
      end
      S_POP, S_DONE: begin
        log_idx = '0;
      end
      default: begin
        log_idx = '0;
      end
    endcase
    ram_waddr = phys_addr;
    ram_raddr = (state == S_IDLE) ? head : phys_addr;
  end

  // Sequencer state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item      <= in_req.item;
            if (in_req.req_type == REQ_INSERT) begin
              if (count == CNT_W'(DEPTH)) begin
                res   <= make_res(ST_FULL, 1'b0, in_req.item, count);
                state <= S_DONE;
              end else if (count == '0) begin
                pos   <= '0;
                state <= S_WRITE;
              end else begin
                scan  <= IDX_W'(count - 1'b1);
                state <= S_READ;
              end
            end else begin
              if (count == '0) begin
                res   <= make_res(ST_EMPTY, 1'b0, in_req.item, count);
                state <= S_DONE;
              end else begin
                state <= S_POP;
              end
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          // Shift a lower entry back one slot, or stop behind an equal or higher one
          if (is_less) begin
            if (scan == '0) begin
              pos   <= '0;
              state <= S_WRITE;
            end else begin
              scan  <= scan - 1'b1;
              state <= S_READ;
            end
          end else begin
            pos   <= scan + 1'b1;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          count <= count + 1'b1;
          res   <= make_res(ST_DONE, 1'b0, item, count + 1'b1);
          state <= S_DONE;
        end
        S_POP: begin
          head  <= head_inc;
          count <= count - 1'b1;
          res   <= make_res(ST_DONE, 1'b1, ram_rdata, count - 1'b1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/sorted_insert_priority_queue.sv @@
// Top level of the sorted-insert priority queue: stream ports and output register.
// Depends on sipq_pkg and sipq_ctrl.
//
// Usage:
//   Requests arrive on the s_ group; s_tuser selects insert (0) or remove (1),
//   s_tdata carries the item. Every request yields exactly one word on the m_
//   group with a status, the removed item when there is one, the entry count
//   and the empty and full flags. Equal priorities leave in arrival order.
// Sequencing:
//   A remove reads the head slot on acceptance and pops it in the pop state.
//   An insert scans backward over j entries (at most the count held):
//   each entry costs one read of the slot memory read port and one compare, and
//   a lower entry is moved back one slot in the compare state. A full or empty
//   refusal writes its result directly on acceptance.
//   s_tready is high only while the sequencer waits for a request.
// Reset:
//   rst empties the queue and drops any pending result; slot contents stay.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   request is still accepted and processed and holds its own result until
//   the register frees up.
module sorted_insert_priority_queue
  import sipq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: in_priority[7:0], in_code[39:8], in_quantity[55:40]
  input  logic [55:0] s_tdata,
  // s_tuser: req_type[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: out_priority[7:0], out_code[39:8], out_quantity[55:40],
  //          entry_count[60:56], is_empty[61], is_full[62], zero[63]
  output logic [63:0] m_tdata,
  // m_tuser: status[1:0], out_valid[2]
  output logic [2:0]  m_tuser
);

  request_t in_req;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  result_t  out_word;

  // Unpack the request word
  assign in_req.req_type  = s_tuser[0];
  assign in_req.item.pri  = PRI_W'(s_tdata[7:0]);
  assign in_req.item.code = s_tdata[39:8];
  assign in_req.item.qty  = s_tdata[55:40];

  sipq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word <= res;
    end
  end

  // Pack the result word
  assign m_tdata = {1'b0, out_word.is_full, out_word.is_empty, out_word.entry_count,
                    out_word.out_quantity, out_word.out_code, out_word.out_priority};
  assign m_tuser = {out_word.out_valid, out_word.status};

endmodule

@@ tb/sorted_insert_priority_queue_tb.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_insert_priority_queue: directed and random insert/remove words,
// checked against an in-bench model of the stable sorted queue. Depends on sipq_pkg.
module sorted_insert_priority_queue_tb;
  import sipq_pkg::*;

  localparam int RANDOM_REQUESTS = 950;
  localparam int QUIET_TAIL      = 120;
  localparam int PRESSURE_AT     = 300;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  // Model of the queue contents, slot 0 at the front
  entry_t   model_slot [DEPTH];
  int       model_held = 0;

  request_t pending_requests [$];
  result_t  expected_words [$];
  request_t offered;
  int       total_requests = 0;
  int       sent_count     = 0;
  int       error_count    = 0;
  int       send_gap       = 0;
  int       stall_left     = 0;
  int       hold_left      = 0;
  int       idle_cycles    = 0;
  bit       pressure_done  = 1'b0;
  bit       calm           = 1'b0;

  sorted_insert_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Last stretch of the run: no idling on either side
  function automatic bit in_tail();
    return pending_requests.size() < QUIET_TAIL;
  endfunction

  // Apply one request to the model queue and return the word it should produce
  function automatic result_t serve_request(request_t req);
    result_t res;
    int      pos;
    int      i;
    res = '0;
    res.status = ST_DONE;
    if (req.req_type == REQ_INSERT) begin
      if (model_held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // land ahead of the first strictly lower entry, so ties keep arrival order
        pos = model_held;
        for (i = 0; i < model_held; i++) begin
          if (pos == model_held && model_slot[i].pri < req.item.pri) pos = i;
        end
        for (i = model_held; i > pos; i--) model_slot[i] = model_slot[i-1];
        model_slot[pos] = req.item;
        model_held++;
      end
    end else begin
      if (model_held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_valid    = 1'b1;
        res.out_priority = model_slot[0].pri;
        res.out_code     = model_slot[0].code;
        res.out_quantity = model_slot[0].qty;
        for (i = 0; i + 1 < model_held; i++) model_slot[i] = model_slot[i+1];
        model_held--;
      end
    end
    res.entry_count = COUNT_FIELD_W'(model_held);
    res.is_empty    = (model_held == 0);
    res.is_full     = (model_held == DEPTH);
    return res;
  endfunction

  task automatic add_request(logic kind, int pri, logic [31:0] code, int qty);
    request_t req;
    req.req_type  = kind;
    req.item.pri  = PRI_W'(pri);
    req.item.code = code;
    req.item.qty  = QTY_W'(qty);
    pending_requests.push_back(req);
  endtask

  // Random runs with a drifting insert/remove mix; some runs crowd priorities for ties
  task automatic add_random_requests(int count);
    int left;
    int run;
    int insert_pct;
    int base;
    int k;
    bit narrow;
    left = count;
    while (left > 0) begin
      run = $urandom_range(10, 40);
      case ($urandom_range(0, 3))
        0:       insert_pct = 20;
        1:       insert_pct = 50;
        2:       insert_pct = 65;
        default: insert_pct = 85;
      endcase
      narrow = $urandom_range(0, 1);
      base   = $urandom_range(0, 252);
      for (k = 0; k < run && left > 0; k++) begin
        add_request(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
                     narrow ? base + $urandom_range(0, 3) : $urandom_range(0, 255),
                     $urandom, $urandom_range(0, 65535));
        left--;
      end
    end
  endtask

  // Sender: hold the offered word until taken, then load the next after an optional gap
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_words.push_back(serve_request(offered));
        sent_count++;
        if (sent_count % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          offered = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {offered.item.qty, offered.item.code, offered.item.pri};
          s_tuser  <= offered.req_type;
          if (!calm && !in_tail() && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 19);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off to back the queue up, otherwise short random stalls
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!pressure_done && sent_count >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      hold_left = PRESSURE_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && !in_tail() && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    string   diff;
    if (!rst && m_tvalid && m_tready) begin
      seen.status       = status_t'(m_tuser[1:0]);
      seen.out_valid    = m_tuser[2];
      seen.out_priority = m_tdata[7:0];
      seen.out_code     = m_tdata[39:8];
      seen.out_quantity = m_tdata[55:40];
      seen.entry_count  = m_tdata[60:56];
      seen.is_empty     = m_tdata[61];
      seen.is_full      = m_tdata[62];
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result word: tuser=%h tdata=%h", m_tuser, m_tdata);
      end else begin
        want = expected_words.pop_front();
        diff = "";
        if (seen.status !== want.status)             diff = {diff, " status"};
        if (seen.out_valid !== want.out_valid)       diff = {diff, " out_valid"};
        if (seen.out_priority !== want.out_priority) diff = {diff, " out_priority"};
        if (seen.out_code !== want.out_code)         diff = {diff, " out_code"};
        if (seen.out_quantity !== want.out_quantity) diff = {diff, " out_quantity"};
        if (seen.entry_count !== want.entry_count)   diff = {diff, " entry_count"};
        if (seen.is_empty !== want.is_empty)         diff = {diff, " is_empty"};
        if (seen.is_full !== want.is_full)           diff = {diff, " is_full"};
        if (diff != "") begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch in%s", diff);
            $display("  expected st=%0d v=%0d pri=%h code=%h qty=%h cnt=%0d e=%0d f=%0d",
                     want.status, want.out_valid, want.out_priority, want.out_code,
                     want.out_quantity, want.entry_count, want.is_empty, want.is_full);
            $display("  actual   st=%0d v=%0d pri=%h code=%h qty=%h cnt=%0d e=%0d f=%0d",
                     seen.status, seen.out_valid, seen.out_priority, seen.out_code,
                     seen.out_quantity, seen.entry_count, seen.is_empty, seen.is_full);
          end
        end
      end
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_insert_priority_queue_tb NOT OK");
      $finish;
    end
  end

  initial begin : run_test
    int dir_pri [14];
    int i;
    dir_pri = '{128, 128, 128, 255, 0, 1, 254, 127, 64, 200, 128, 7, 3, 100};
    // Directed: remove on empty, fill with extremes and ties, overflow, partial drain
    add_request(REQ_REMOVE, 0, 32'h0000_0000, 0);
    add_request(REQ_INSERT, 255, 32'hFFFF_FFFF, 16'hFFFF);
    add_request(REQ_INSERT, 0, 32'h0000_0000, 0);
    for (i = 0; i < 14; i++) add_request(REQ_INSERT, dir_pri[i], 32'h5A00_0000 + i, i + 1);
    add_request(REQ_INSERT, 255, 32'h1234_5678, 16'h0F0F);
    for (i = 0; i < 5; i++) add_request(REQ_REMOVE, 8'hAA, 32'hC0DE_0000 + i, 16'h5555);
    add_random_requests(RANDOM_REQUESTS);
    total_requests = pending_requests.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every result to come back
    while (sent_count < total_requests || expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("sorted_insert_priority_queue_tb OK");
    end else begin
      $display("sorted_insert_priority_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
